// File: rtl/core/lru_buffer_pool_pin_dirty_macros.svh
// ----------------------------------------------------------------------------
// lru_buffer_pool_pin_dirty_macros
// assertion macros used by the checker file of the buffer pool engine
// ----------------------------------------------------------------------------
`ifndef LRU_BUFFER_POOL_PIN_DIRTY_MACROS_SVH
`define LRU_BUFFER_POOL_PIN_DIRTY_MACROS_SVH

// property that holds in the same cycle as its antecedent
`define LBPPD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that holds in the cycle after its antecedent
`define LBPPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lbppd_pkg.sv
// ----------------------------------------------------------------------------
// lbppd_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package lbppd_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int SLOT_W    = 4;
    localparam int CMD_W     = 3;
    localparam int FILE_W    = 8;
    localparam int BLOCK_W   = 32;
    localparam int STATUS_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET   = 3'd0,
        CMD_PIN   = 3'd1,
        CMD_UNPIN = 3'd2,
        CMD_DIRTY = 3'd3,
        CMD_DROP  = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT       = 3'd0,
        ST_LOAD      = 3'd1,
        ST_APPEND    = 3'd2,
        ST_INVALID   = 3'd3,
        ST_ALLOCATED = 3'd4,
        ST_NOT_RES   = 3'd5,
        ST_NO_VICTIM = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TOUCH,
        OP_FILL,
        OP_PIN,
        OP_UNPIN,
        OP_DIRTY,
        OP_SCAN_CLR,
        OP_SCAN,
        OP_EVICT,
        OP_DROP
    } t_op;

    typedef struct packed {
        t_op     op;
        logic    emit;
        t_status status;
        logic    slot_en;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             new_block;
        logic             hit;
        logic             free_ok;
        logic             bid_lt;
        logic             bid_eq;
        logic             drop_hit;
        logic             scan_done;
        logic             victim_ok;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/core/lbppd_ctrl.sv
// ----------------------------------------------------------------------------
// lbppd_ctrl
// sequencing state machine: lookup, victim scan, eviction and file drop
// ----------------------------------------------------------------------------
`default_nettype none

module lbppd_ctrl
    import lbppd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_dp_stat i_stat,
    output logic          o_busy,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_EVICT,
        S_DROP
    } t_state;

    t_state  r_state, n_state;
    logic    r_busy, n_busy;
    t_dp_cmd c;
    logic    bad_get;
    t_status miss_st;

    assign bad_get = (!i_stat.bid_lt && !i_stat.bid_eq) || (i_stat.bid_eq && !i_stat.new_block);
    assign miss_st = i_stat.bid_eq ? ST_APPEND : ST_LOAD;

    always_comb begin
        n_state   = r_state;
        n_busy    = r_busy;
        c.op      = OP_NONE;
        c.emit    = 1'b0;
        c.status  = ST_HIT;
        c.slot_en = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && !r_busy) begin
                    c.op    = OP_LOAD;
                    n_state = S_LOOKUP;
                    n_busy  = 1'b1;
                end
            end
            S_LOOKUP: begin
                unique case (i_stat.cmd) inside
                    CMD_GET: begin
                        if (i_stat.hit) begin
                            c.op      = OP_TOUCH;
                            c.emit    = 1'b1;
                            c.slot_en = 1'b1;
                        end else if (bad_get) begin
                            c.emit   = 1'b1;
                            c.status = ST_INVALID;
                        end else if (i_stat.bid_lt && i_stat.new_block) begin
                            c.emit   = 1'b1;
                            c.status = ST_ALLOCATED;
                        end else if (i_stat.free_ok) begin
                            c.op      = OP_FILL;
                            c.emit    = 1'b1;
                            c.status  = miss_st;
                            c.slot_en = 1'b1;
                        end else begin
                            c.op    = OP_SCAN_CLR;
                            n_state = S_SCAN;
                        end
                    end
                    CMD_PIN, CMD_UNPIN, CMD_DIRTY: begin
                        c.emit = 1'b1;
                        if (!i_stat.bid_lt) begin
                            c.status = ST_INVALID;
                        end else if (!i_stat.hit) begin
                            c.status = ST_NOT_RES;
                        end else begin
                            c.slot_en = 1'b1;
                            if (i_stat.cmd == CMD_PIN) begin
                                c.op = OP_PIN;
                            end else if (i_stat.cmd == CMD_UNPIN) begin
                                c.op = OP_UNPIN;
                            end else begin
                                c.op = OP_DIRTY;
                            end
                        end
                    end
                    CMD_DROP: begin
                        n_state = S_DROP;
                    end
                    default: begin
                        c.emit = 1'b1;
                    end
                endcase
            end
            S_SCAN: begin
                c.op = OP_SCAN;
                if (i_stat.scan_done) begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                c.emit = 1'b1;
                if (i_stat.victim_ok) begin
                    c.op      = OP_EVICT;
                    c.status  = miss_st;
                    c.slot_en = 1'b1;
                end else begin
                    c.status = ST_NO_VICTIM;
                end
            end
            S_DROP: begin
                if (i_stat.drop_hit) begin
                    c.op = OP_DROP;
                end else begin
                    c.emit = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
        if (c.emit) begin
            n_state = S_IDLE;
            n_busy  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;
    assign o_cmd  = c;

endmodule

`default_nettype wire

// File: rtl/core/lbppd_dp.sv
// ----------------------------------------------------------------------------
// lbppd_dp
// slot table with parallel tag match, recency ranks, victim scan and result
// ----------------------------------------------------------------------------
`default_nettype none

module lbppd_dp
    import lbppd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [CMD_W-1:0]   i_cmd,
    input  wire logic [FILE_W-1:0]  i_file_id,
    input  wire logic [BLOCK_W-1:0] i_block_id,
    input  wire logic               i_new_block,
    input  wire logic [BLOCK_W-1:0] i_file_blocks,
    input  wire t_dp_cmd            i_ctl,
    output t_dp_stat                o_stat,
    output logic                    o_valid,
    output logic [STATUS_W-1:0]     o_status,
    output logic [SLOT_W-1:0]       o_slot,
    output logic                    o_writeback,
    output logic [FILE_W-1:0]       o_evict_file,
    output logic [BLOCK_W-1:0]      o_evict_block
);

    logic [NUM_SLOTS-1:0] r_valid, r_pin, r_dirty;
    logic [IDX_W-1:0]     r_rank  [NUM_SLOTS];
    logic [FILE_W-1:0]    r_file  [NUM_SLOTS];
    logic [BLOCK_W-1:0]   r_block [NUM_SLOTS];

    logic [CMD_W-1:0]     r_cmd;
    logic [FILE_W-1:0]    r_fid;
    logic [BLOCK_W-1:0]   r_bid;
    logic                 r_nb;
    logic [BLOCK_W-1:0]   r_fblk;

    logic [IDX_W-1:0]     r_scan_idx;
    logic                 r_vic_ok;
    logic [IDX_W-1:0]     r_vic_idx;
    logic [IDX_W-1:0]     r_vic_rank;

    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic [SLOT_W-1:0]    r_out_slot;
    logic                 r_out_wb;
    logic [FILE_W-1:0]    r_out_file;
    logic [BLOCK_W-1:0]   r_out_block;

    logic [NUM_SLOTS-1:0] match, drop_match;
    logic [IDX_W-1:0]     hit_idx, free_idx, drop_idx, sel_idx;
    logic                 free_any;
    logic [IDX_W-1:0]     sel_rank;
    logic                 sel_pin, sel_dirty;
    logic [FILE_W-1:0]    sel_file;
    logic [BLOCK_W-1:0]   sel_block;

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        drop_idx = '0;
        free_any = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            drop_match[i] = r_valid[i] && (r_file[i] == r_fid);
            match[i]      = drop_match[i] && (r_block[i] == r_bid);
            if (match[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (drop_match[i]) begin
                drop_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
                free_any = 1'b1;
            end
        end
    end

    always_comb begin
        unique case (i_ctl.op)
            OP_FILL:  sel_idx = free_idx;
            OP_SCAN:  sel_idx = r_scan_idx;
            OP_EVICT: sel_idx = r_vic_idx;
            OP_DROP:  sel_idx = drop_idx;
            default:  sel_idx = hit_idx;
        endcase
    end

    assign sel_rank  = r_rank[sel_idx];
    assign sel_pin   = r_pin[sel_idx];
    assign sel_dirty = r_dirty[sel_idx];
    assign sel_file  = r_file[sel_idx];
    assign sel_block = r_block[sel_idx];

    assign o_stat.cmd       = r_cmd;
    assign o_stat.new_block = r_nb;
    assign o_stat.hit       = |match;
    assign o_stat.free_ok   = free_any;
    assign o_stat.bid_lt    = r_bid < r_fblk;
    assign o_stat.bid_eq    = r_bid == r_fblk;
    assign o_stat.drop_hit  = |drop_match;
    assign o_stat.scan_done = r_scan_idx == IDX_W'(NUM_SLOTS - 1);
    assign o_stat.victim_ok = r_vic_ok;

    // table state and ranks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_pin       <= '0;
            r_dirty     <= '0;
            r_rank      <= '{default: '0};
            r_scan_idx  <= '0;
            r_vic_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_ctl.emit;
            case (i_ctl.op)
                OP_TOUCH, OP_EVICT: begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (r_valid[i] && (IDX_W'(i) != sel_idx) && (r_rank[i] < sel_rank)) begin
                            r_rank[i] <= r_rank[i] + 1'b1;
                        end
                    end
                    r_rank[sel_idx] <= '0;
                    if (i_ctl.op == OP_EVICT) begin
                        r_pin[sel_idx]   <= 1'b0;
                        r_dirty[sel_idx] <= 1'b0;
                    end
                end
                OP_FILL: begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (r_valid[i]) begin
                            r_rank[i] <= r_rank[i] + 1'b1;
                        end
                    end
                    r_rank[sel_idx]  <= '0;
                    r_valid[sel_idx] <= 1'b1;
                    r_pin[sel_idx]   <= 1'b0;
                    r_dirty[sel_idx] <= 1'b0;
                end
                OP_PIN: begin
                    r_pin[sel_idx] <= 1'b1;
                end
                OP_UNPIN: begin
                    r_pin[sel_idx] <= 1'b0;
                end
                OP_DIRTY: begin
                    r_dirty[sel_idx] <= 1'b1;
                end
                OP_SCAN_CLR: begin
                    r_scan_idx <= '0;
                    r_vic_ok   <= 1'b0;
                end
                OP_SCAN: begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                    if (!sel_pin && (!r_vic_ok || (sel_rank > r_vic_rank))) begin
                        r_vic_ok   <= 1'b1;
                        r_vic_idx  <= sel_idx;
                        r_vic_rank <= sel_rank;
                    end
                end
                OP_DROP: begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (r_valid[i] && (IDX_W'(i) != sel_idx) && (r_rank[i] > sel_rank)) begin
                            r_rank[i] <= r_rank[i] - 1'b1;
                        end
                    end
                    r_valid[sel_idx] <= 1'b0;
                    r_pin[sel_idx]   <= 1'b0;
                    r_dirty[sel_idx] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // tags, latched request and result word
    always_ff @(posedge i_clk) begin
        if (i_ctl.op == OP_LOAD) begin
            r_cmd  <= i_cmd;
            r_fid  <= i_file_id;
            r_bid  <= i_block_id;
            r_nb   <= i_new_block;
            r_fblk <= i_file_blocks;
        end
        if ((i_ctl.op == OP_FILL) || (i_ctl.op == OP_EVICT)) begin
            r_file[sel_idx]  <= r_fid;
            r_block[sel_idx] <= r_bid;
        end
        if (i_ctl.emit) begin
            r_out_status <= i_ctl.status;
            r_out_slot   <= i_ctl.slot_en ? SLOT_W'(sel_idx) : '0;
            if ((i_ctl.op == OP_EVICT) && sel_dirty) begin
                r_out_wb    <= 1'b1;
                r_out_file  <= sel_file;
                r_out_block <= sel_block;
            end else begin
                r_out_wb    <= 1'b0;
                r_out_file  <= '0;
                r_out_block <= '0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot        = r_out_slot;
    assign o_writeback   = r_out_wb;
    assign o_evict_file  = r_out_file;
    assign o_evict_block = r_out_block;

endmodule

`default_nettype wire

// File: rtl/core/lru_buffer_pool_pin_dirty.sv
// ----------------------------------------------------------------------------
// lru_buffer_pool_pin_dirty
// buffer pool tag and replacement engine with lru order, pin and dirty marks
// ----------------------------------------------------------------------------
// a request word (command, file, block, append flag, file length) is taken
// at a rising edge with start high and busy low. busy rises at that edge and
// falls at the edge that registers the result; the result word is on the
// o_ ports for one cycle with o_valid high, and must be taken then.
// latency from the accepting edge to the result cycle:
//   hit, pin/unpin/dirty, invalid block, already allocated, not resident,
//   unused-slot fill, unknown command : 2 cycles
//   miss with eviction or no victim : 3 + NUM_SLOTS cycles (one slot compared
//     per cycle in the victim scan, then one cycle for eviction and recency)
//   drop file : 3 + k cycles, k = slots held by the file (one lookup cycle,
//     then one removal and rank compaction per cycle, then the result)
// a new request may be taken at the edge that ends the result cycle, so a
// 2-cycle item repeats every 2 cycles. tag compare runs across all slots in
// one cycle.
// reset (synchronous, active low) empties every slot and clears pins, dirty
// marks and ranks; the block is ready the cycle after reset is released.
// the receiver cannot stall: each result word is shown once only.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_buffer_pool_pin_dirty
    import lbppd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic [CMD_W-1:0]   i_cmd,
    input  wire logic [FILE_W-1:0]  i_file_id,
    input  wire logic [BLOCK_W-1:0] i_block_id,
    input  wire logic               i_new_block,
    input  wire logic [BLOCK_W-1:0] i_file_blocks,
    output logic                    busy,
    output logic                    o_valid,
    output logic [STATUS_W-1:0]     o_status,
    output logic [SLOT_W-1:0]       o_slot,
    output logic                    o_writeback,
    output logic [FILE_W-1:0]       o_evict_file,
    output logic [BLOCK_W-1:0]      o_evict_block
);

    t_dp_cmd  ctl;
    t_dp_stat stat;

    lbppd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (ctl)
    );

    lbppd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (i_cmd),
        .i_file_id     (i_file_id),
        .i_block_id    (i_block_id),
        .i_new_block   (i_new_block),
        .i_file_blocks (i_file_blocks),
        .i_ctl         (ctl),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_writeback   (o_writeback),
        .o_evict_file  (o_evict_file),
        .o_evict_block (o_evict_block)
    );

endmodule

`default_nettype wire

// File: rtl/core/lbppd_chk.sv
// ----------------------------------------------------------------------------
// lbppd_chk
// port-level checks on the buffer pool engine, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_buffer_pool_pin_dirty_macros.svh"

module lbppd_chk
    import lbppd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic                o_valid,
    input  wire logic [STATUS_W-1:0] o_status,
    input  wire logic [SLOT_W-1:0]   o_slot,
    input  wire logic                o_writeback
);

    logic load_like, no_slot;

    assign load_like = (o_status == ST_LOAD) || (o_status == ST_APPEND);
    assign no_slot   = (o_status == ST_INVALID) || (o_status == ST_ALLOCATED)
                    || (o_status == ST_NOT_RES) || (o_status == ST_NO_VICTIM);

    `LBPPD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised on accept")
    `LBPPD_ASSERT_SAME(a_word_idle, i_clk, i_rst_n, o_valid, !busy && $past(busy), "result word outside a busy spell")
    `LBPPD_ASSERT_SAME(a_busy_end, i_clk, i_rst_n, $fell(busy), o_valid, "busy fell without a result word")
    `LBPPD_ASSERT_SAME(a_wb_miss, i_clk, i_rst_n, o_valid && !load_like, !o_writeback, "write-back on a non-miss word")
    `LBPPD_ASSERT_SAME(a_slot_zero, i_clk, i_rst_n, o_valid && no_slot, o_slot == '0, "slot set on a failed request")

endmodule

bind lru_buffer_pool_pin_dirty lbppd_chk u_chk (.*);

`default_nettype wire
